[hdl/apsa_pkg.sv]
// ----------------------------------------------------------------------------
// apsa_pkg: shared types and constants for the arcsine datapath
// Coefficients, stage records and rounding helpers.
// ----------------------------------------------------------------------------
package apsa_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CF        = 30;
    localparam int IO_W      = FRAC_BITS + 2;
    localparam int A_W       = FRAC_BITS + 1;
    localparam int V_W       = 2 * A_W;
    localparam int REM_W     = A_W + 3;
    localparam int P_W       = 32;
    localparam int TD_W      = ((IO_W + 7) / 8) * 8;

    localparam logic signed [P_W-1:0] C_ACC0  = 32'sd1686557207;
    localparam logic signed [P_W-1:0] C_ACC1  = -32'sd227756103;
    localparam logic signed [P_W-1:0] C_ACC2  = 32'sd79737142;
    localparam logic signed [P_W-1:0] C_ACC3  = -32'sd20110433;
    localparam logic signed [P_W-1:0] C_FAST0 = 32'sd1686629713;
    localparam logic signed [P_W-1:0] C_FAST1 = -32'sd222302592;
    localparam logic signed [P_W-1:0] C_FAST2 = 32'sd57019938;
    localparam logic signed [P_W-1:0] HALF_PI = 32'sd1686629713;

    localparam logic MODE_ACCURATE = 1'b0;

    typedef struct packed {
        logic                    valid;
        logic                    mode;
        logic                    neg;
        logic                    flag;
        logic [A_W-1:0]          a;
        logic [A_W-1:0]          d;
        logic signed [P_W-1:0]   h;
    } t_hstage;

    typedef struct packed {
        logic                    valid;
        logic                    neg;
        logic                    flag;
        logic signed [P_W-1:0]   p;
        logic [REM_W-1:0]        rem;
        logic [A_W-1:0]          root;
        logic [V_W-1:0]          v;
    } t_sstage;

    // divide by 2^FRAC_BITS, round half away from zero
    function automatic logic signed [63:0] rnd_frac(input logic signed [63:0] v);
        logic [63:0] mag;
        mag = v[63] ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v[63] ? -$signed(mag) : $signed(mag);
    endfunction

    // divide by 2^(CF-FRAC_BITS), round half away from zero
    function automatic logic signed [63:0] rnd_out(input logic signed [63:0] v);
        logic [63:0] mag;
        mag = v[63] ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (CF - FRAC_BITS - 1))) >> (CF - FRAC_BITS);
        return v[63] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

[hdl/apsa_horner_cell.sv]
// ----------------------------------------------------------------------------
// apsa_horner_cell: one Horner step of the polynomial
// h_next = coef + rnd(h * a), coefficient picked by the item's mode.
// ----------------------------------------------------------------------------
module apsa_horner_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic signed [apsa_pkg::P_W-1:0] i_coef_acc,
    input  logic signed [apsa_pkg::P_W-1:0] i_coef_fast,
    input  apsa_pkg::t_hstage              i_stage,
    output apsa_pkg::t_hstage              o_stage
);
    apsa_pkg::t_hstage r_stage;
    apsa_pkg::t_hstage n_stage;
    logic signed [63:0] w_prod;
    logic signed [apsa_pkg::P_W-1:0] w_coef;

    always_comb begin
        w_prod  = 64'(i_stage.h) * $signed({47'd0, i_stage.a});
        w_coef  = (i_stage.mode == apsa_pkg::MODE_ACCURATE) ? i_coef_acc : i_coef_fast;
        n_stage = i_stage;
        n_stage.h = w_coef + apsa_pkg::P_W'(apsa_pkg::rnd_frac(w_prod));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_en) begin
            r_stage.mode <= n_stage.mode;
            r_stage.neg  <= n_stage.neg;
            r_stage.flag <= n_stage.flag;
            r_stage.a    <= n_stage.a;
            r_stage.d    <= n_stage.d;
            r_stage.h    <= n_stage.h;
        end
    end

    assign o_stage = r_stage;
endmodule

[hdl/apsa_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// apsa_sqrt_cell: one digit of the restoring square root
// Brings in two radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module apsa_sqrt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  apsa_pkg::t_sstage i_stage,
    output apsa_pkg::t_sstage o_stage
);
    apsa_pkg::t_sstage r_stage;
    apsa_pkg::t_sstage n_stage;
    logic [apsa_pkg::REM_W-1:0] w_rem;
    logic [apsa_pkg::REM_W-1:0] w_trial;

    always_comb begin
        w_rem   = {i_stage.rem[apsa_pkg::REM_W-3:0], i_stage.v[apsa_pkg::V_W-1 -: 2]};
        w_trial = apsa_pkg::REM_W'({i_stage.root, 2'b01});
        n_stage = i_stage;
        n_stage.v = {i_stage.v[apsa_pkg::V_W-3:0], 2'b00};
        if (w_rem >= w_trial) begin
            n_stage.rem  = w_rem - w_trial;
            n_stage.root = {i_stage.root[apsa_pkg::A_W-2:0], 1'b1};
        end else begin
            n_stage.rem  = w_rem;
            n_stage.root = {i_stage.root[apsa_pkg::A_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_en) begin
            r_stage.neg  <= n_stage.neg;
            r_stage.flag <= n_stage.flag;
            r_stage.p    <= n_stage.p;
            r_stage.rem  <= n_stage.rem;
            r_stage.root <= n_stage.root;
            r_stage.v    <= n_stage.v;
        end
    end

    assign o_stage = r_stage;
endmodule

[hdl/asin_poly_sqrt_approx.sv]
// ----------------------------------------------------------------------------
// asin_poly_sqrt_approx: fixed-point arcsine, pi/2 - sqrt(1-|x|)*P(|x|)
// Input stage, three Horner cells, a row of square-root cells, a product stage
// and rounding into the output register.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                         | transaction
//  s_axis    | in  | tdata: x_value[17:0]            | tvalid & tready
//  m_axis    | out | tdata: angle[17:0], tuser: oor  | tvalid & tready
//  cfg       | in  | data: poly_mode                 | valid & ready
//
// One item per cycle while the output is not held. Registers in order: input stage,
// three Horner cells, FRAC_BITS+1 square-root cells (one root bit per cell), the
// product register and the output register. All stages advance together; they hold
// only while the output register is full and not taken. Reset clears the valid bits and sets poly_mode to accurate.
// ----------------------------------------------------------------------------
module asin_poly_sqrt_approx (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [apsa_pkg::TD_W-1:0]   i_s_axis_tdata,   // x_value
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [apsa_pkg::TD_W-1:0]   o_m_axis_tdata,   // angle
    output logic                        o_m_axis_tuser,   // out_of_range
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_data
);
    localparam int NS = apsa_pkg::A_W;

    logic w_en;
    logic r_mode;
    apsa_pkg::t_hstage r_in;
    apsa_pkg::t_hstage h_st [0:3];
    apsa_pkg::t_sstage s_st [0:NS];
    logic signed [apsa_pkg::P_W-1:0] w_acc [0:2];
    logic signed [apsa_pkg::P_W-1:0] w_fast [0:2];

    logic signed [apsa_pkg::IO_W-1:0] w_x;
    logic [apsa_pkg::IO_W:0] w_abs;

    logic r_m_valid, r_m_neg, r_m_flag;
    logic signed [63:0] r_prod;
    logic r_out_valid, r_out_flag;
    logic [apsa_pkg::IO_W-1:0] r_out_angle;
    logic signed [63:0] w_y;
    logic signed [63:0] w_mag;

    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= apsa_pkg::MODE_ACCURATE;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    // magnitude and clamp
    always_comb begin
        w_x   = $signed(i_s_axis_tdata[apsa_pkg::IO_W-1:0]);
        w_abs = w_x[apsa_pkg::IO_W-1] ? (apsa_pkg::IO_W+1)'(-{w_x[apsa_pkg::IO_W-1], w_x})
                                       : (apsa_pkg::IO_W+1)'({w_x[apsa_pkg::IO_W-1], w_x});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (w_en) begin
            r_in.valid <= i_s_axis_tvalid;
        end
        if (w_en) begin
            r_in.mode <= r_mode;
            r_in.neg  <= w_x[apsa_pkg::IO_W-1];
            if (w_abs > (apsa_pkg::IO_W+1)'(1 << apsa_pkg::FRAC_BITS)) begin
                r_in.flag <= 1'b1;
                r_in.a    <= apsa_pkg::A_W'(1 << apsa_pkg::FRAC_BITS);
                r_in.d    <= '0;
            end else begin
                r_in.flag <= 1'b0;
                r_in.a    <= apsa_pkg::A_W'(w_abs);
                r_in.d    <= apsa_pkg::A_W'((1 << apsa_pkg::FRAC_BITS)) - apsa_pkg::A_W'(w_abs);
            end
            r_in.h <= '0;
        end
    end

    // fast mode starts from zero so its first step yields the top coefficient
    always_comb begin
        h_st[0]   = r_in;
        h_st[0].h = (r_in.mode == apsa_pkg::MODE_ACCURATE) ? apsa_pkg::C_ACC3 : '0;
    end

    assign w_acc[0]  = apsa_pkg::C_ACC2;
    assign w_acc[1]  = apsa_pkg::C_ACC1;
    assign w_acc[2]  = apsa_pkg::C_ACC0;
    assign w_fast[0] = apsa_pkg::C_FAST2;
    assign w_fast[1] = apsa_pkg::C_FAST1;
    assign w_fast[2] = apsa_pkg::C_FAST0;

    for (genvar g = 0; g < 3; g++) begin : g_horner
        apsa_horner_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (w_en),
            .i_coef_acc  (w_acc[g]),
            .i_coef_fast (w_fast[g]),
            .i_stage     (h_st[g]),
            .o_stage     (h_st[g+1])
        );
    end

    always_comb begin
        s_st[0].valid = h_st[3].valid;
        s_st[0].neg   = h_st[3].neg;
        s_st[0].flag  = h_st[3].flag;
        s_st[0].p     = h_st[3].h;
        s_st[0].rem   = '0;
        s_st[0].root  = '0;
        s_st[0].v     = apsa_pkg::V_W'({h_st[3].d, apsa_pkg::FRAC_BITS'(0)});
    end

    for (genvar g = 0; g < NS; g++) begin : g_sqrt
        apsa_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (s_st[g]),
            .o_stage (s_st[g+1])
        );
    end

    // s * P
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_en) begin
            r_m_valid <= s_st[NS].valid;
        end
        if (w_en) begin
            r_m_neg  <= s_st[NS].neg;
            r_m_flag <= s_st[NS].flag;
            r_prod   <= $signed({47'd0, s_st[NS].root}) * 64'(s_st[NS].p);
        end
    end

    always_comb begin
        w_y   = 64'(apsa_pkg::HALF_PI) - apsa_pkg::rnd_frac(r_prod);
        w_mag = apsa_pkg::rnd_out(w_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_m_valid;
        end
        if (w_en) begin
            r_out_flag  <= r_m_flag;
            r_out_angle <= r_m_neg ? apsa_pkg::IO_W'(-w_mag) : apsa_pkg::IO_W'(w_mag);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = apsa_pkg::TD_W'(r_out_angle);
    assign o_m_axis_tuser  = r_out_flag;
endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: stream testbench for asin_poly_sqrt_approx
// Drives signed samples through the arcsine pipeline in both polynomial
// modes, predicts or tabulates each angle and range flag, and checks them in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int N_RANDOM   = 1350;
    localparam int DRAIN_CYC  = 40;
    localparam int WDOG_LIMIT = 2000;

    typedef struct packed {
        logic [apsa_pkg::IO_W-1:0] angle;
        logic                      oor;
    } t_angle_res;

    typedef struct {
        logic [apsa_pkg::IO_W-1:0] x;
        logic                      has_exp;
        logic [apsa_pkg::IO_W-1:0] angle;
        logic                      oor;
    } t_dir_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [apsa_pkg::TD_W-1:0]   s_tdata = '0;     // x_value
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [apsa_pkg::TD_W-1:0]   m_tdata;          // angle
    logic                        m_tuser;          // out_of_range
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic                        cfg_data = 1'b0;

    t_angle_res         angle_q[$];
    logic               mode_shadow = apsa_pkg::MODE_ACCURATE;
    int                 fails = 0;
    int                 idle_cyc = 0;
    int                 out_wait = 0;
    logic               stim_done = 1'b0;
    logic               mon_on = 1'b0;
    t_dir_row           dir_rows[$];

    always #6 i_clk = ~i_clk;

    asin_poly_sqrt_approx dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    function automatic longint round_div(longint v, int s);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r;
        r = 0;
        for (int b = 20; b >= 0; b--)
            if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= v)
                r = r + (64'sd1 <<< b);
        return r;
    endfunction

    function automatic t_angle_res predict_asin(logic [apsa_pkg::IO_W-1:0] x, logic mode);
        t_angle_res r;
        logic       neg;
        longint     mag;
        longint     poly;
        longint     root;
        longint     y;
        neg = x[apsa_pkg::IO_W-1];
        mag = neg ? longint'((1 << apsa_pkg::IO_W) - int'(x)) : longint'(x);
        r.oor = 1'b0;
        if (mag > (64'sd1 <<< apsa_pkg::FRAC_BITS)) begin
            mag = 64'sd1 <<< apsa_pkg::FRAC_BITS;
            r.oor = 1'b1;
        end
        if (mode == apsa_pkg::MODE_ACCURATE) begin
            poly = apsa_pkg::C_ACC3;
            poly = apsa_pkg::C_ACC2 + round_div(poly * mag, apsa_pkg::FRAC_BITS);
            poly = apsa_pkg::C_ACC1 + round_div(poly * mag, apsa_pkg::FRAC_BITS);
            poly = apsa_pkg::C_ACC0 + round_div(poly * mag, apsa_pkg::FRAC_BITS);
        end else begin
            poly = apsa_pkg::C_FAST2;
            poly = apsa_pkg::C_FAST1 + round_div(poly * mag, apsa_pkg::FRAC_BITS);
            poly = apsa_pkg::C_FAST0 + round_div(poly * mag, apsa_pkg::FRAC_BITS);
        end
        root = int_sqrt(((64'sd1 <<< apsa_pkg::FRAC_BITS) - mag) <<< apsa_pkg::FRAC_BITS);
        y = apsa_pkg::HALF_PI - round_div(root * poly, apsa_pkg::FRAC_BITS);
        y = round_div(y, apsa_pkg::CF - apsa_pkg::FRAC_BITS);
        r.angle = neg ? apsa_pkg::IO_W'(-y) : apsa_pkg::IO_W'(y);
        return r;
    endfunction

    function automatic int draw_wait();
        return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16));
    endfunction

    task automatic wait_cycles(int n);
        repeat (n) @(posedge i_clk);
    endtask

    // send one sample, queue its expected result at acceptance; tvalid is
    // left high so a zero-gap follower needs no second drive in this step
    task automatic send_sample(logic [apsa_pkg::IO_W-1:0] x);
        int n;
        n = draw_wait();
        if (n > 0) begin
            s_tvalid <= 1'b0;
            wait_cycles(n);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= apsa_pkg::TD_W'(x);
        do @(posedge i_clk); while (!s_tready);
        angle_q.push_back(predict_asin(x, mode_shadow));
    endtask

    task automatic write_mode(logic m);
        s_tvalid <= 1'b0;
        while (angle_q.size() != 0) @(posedge i_clk);
        wait_cycles(DRAIN_CYC);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        mode_shadow = m;
    endtask

    function automatic logic [apsa_pkg::IO_W-1:0] rand_sample();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            return apsa_pkg::IO_W'($urandom_range(0, 2 * (1 << apsa_pkg::FRAC_BITS))
                                   - (1 << apsa_pkg::FRAC_BITS));
        else if (sel < 9)
            return apsa_pkg::IO_W'($urandom);
        return apsa_pkg::IO_W'($urandom_range(0, 1)
                               ? (1 << apsa_pkg::FRAC_BITS) - $urandom_range(0, 8)
                               : -(1 << apsa_pkg::FRAC_BITS) + $urandom_range(0, 8));
    endfunction

    function automatic t_dir_row row(int x, logic he, int ang, logic oor);
        t_dir_row r;
        r.x = apsa_pkg::IO_W'(x);
        r.has_exp = he;
        r.angle = apsa_pkg::IO_W'(ang);
        r.oor = oor;
        return r;
    endfunction

    // output side: per-transaction stalls, compare against oldest expectation
    always @(posedge i_clk) begin
        if (mon_on) begin
            if (m_tvalid && m_tready) begin
                if (angle_q.size() == 0) begin
                    $error("unexpected result angle=%0h", m_tdata[apsa_pkg::IO_W-1:0]);
                    fails++;
                end else begin
                    t_angle_res e;
                    e = angle_q.pop_front();
                    if (m_tdata[apsa_pkg::IO_W-1:0] !== e.angle) begin
                        $error("angle: expected %0h actual %0h", e.angle,
                               m_tdata[apsa_pkg::IO_W-1:0]);
                        fails++;
                    end
                    if (m_tuser !== e.oor) begin
                        $error("out_of_range: expected %0b actual %0b", e.oor, m_tuser);
                        fails++;
                    end
                end
                out_wait = draw_wait();
            end
            if (out_wait > 0) begin
                m_tready <= 1'b0;
                out_wait = out_wait - 1;
            end else begin
                m_tready <= 1'b1;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !s_tvalid && stim_done
                && angle_q.size() == 0)
                idle_cyc <= 0;
            else
                idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= WDOG_LIMIT) begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        t_angle_res e;
        // directed points: +-1 give +-pi/2, overrange clamps and flags; the rest are predicted
        dir_rows.push_back(row(0, 1'b0, 0, 1'b0));
        dir_rows.push_back(row(1 << apsa_pkg::FRAC_BITS, 1'b1, 102944, 1'b0));
        dir_rows.push_back(row(-(1 << apsa_pkg::FRAC_BITS), 1'b1, -102944, 1'b0));
        dir_rows.push_back(row((1 << apsa_pkg::FRAC_BITS) + 1, 1'b1, 102944, 1'b1));
        dir_rows.push_back(row(131071, 1'b1, 102944, 1'b1));
        dir_rows.push_back(row(-131072, 1'b1, -102944, 1'b1));
        dir_rows.push_back(row(-(1 << apsa_pkg::FRAC_BITS) - 1, 1'b1, -102944, 1'b1));
        dir_rows.push_back(row(1, 1'b0, 0, 1'b0));
        dir_rows.push_back(row(-1, 1'b0, 0, 1'b0));
        dir_rows.push_back(row(1 << (apsa_pkg::FRAC_BITS - 1), 1'b0, 0, 1'b0));
        dir_rows.push_back(row(-(1 << (apsa_pkg::FRAC_BITS - 1)), 1'b0, 0, 1'b0));
        dir_rows.push_back(row(65535, 1'b0, 0, 1'b0));
        dir_rows.push_back(row(-65535, 1'b0, 0, 1'b0));
        dir_rows.push_back(row(43690, 1'b0, 0, 1'b0));

        wait_cycles(2);
        i_rst_n <= 1'b1;
        mon_on  <= 1'b1;
        @(posedge i_clk);
        for (int m = 0; m < 3; m++) begin
            if (m > 0) write_mode(m[0]);
            foreach (dir_rows[i]) begin
                send_sample(dir_rows[i].x);
                if (dir_rows[i].has_exp) begin
                    e = angle_q.pop_back();
                    e.angle = dir_rows[i].angle;
                    e.oor = dir_rows[i].oor;
                    angle_q.push_back(e);
                end
            end
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 300 == 299) write_mode($urandom_range(0, 1));
            if ($urandom_range(0, 4) == 0) begin
                // back-to-back burst
                s_tvalid <= 1'b1;
                s_tdata <= apsa_pkg::TD_W'(rand_sample());
                for (int k = 0; k < 8; k++) begin
                    do @(posedge i_clk); while (!s_tready);
                    angle_q.push_back(predict_asin(s_tdata[apsa_pkg::IO_W-1:0],
                                                   mode_shadow));
                    if (k < 7) s_tdata <= apsa_pkg::TD_W'(rand_sample());
                end
                i += 7;
            end else begin
                send_sample(rand_sample());
            end
        end
        s_tvalid  <= 1'b0;
        stim_done <= 1'b1;
        while (angle_q.size() != 0) @(posedge i_clk);
        wait_cycles(DRAIN_CYC);
        if (fails == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

[files.f]
hdl/apsa_pkg.sv
hdl/apsa_horner_cell.sv
hdl/apsa_sqrt_cell.sv
hdl/asin_poly_sqrt_approx.sv
test/tb.sv
